### sv/ipdq_pkg.sv
// Shared types and constants for the dotted-quad address validator.
package ipdq_pkg;

    localparam int CHAR_W         = 8;
    localparam int QUEUE_DEPTH    = 4;   // power of two, at least 2
    localparam int CNT_W          = 5;
    localparam int DOT_W          = 3;
    localparam int DIG_W          = 3;
    localparam int VAL_W          = 10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'd46;

    localparam logic [CNT_W-1:0] CNT_SAT  = 5'd16;
    localparam logic [CNT_W-1:0] LEN_MIN  = 5'd7;
    localparam logic [CNT_W-1:0] LEN_MAX  = 5'd15;
    localparam logic [DOT_W-1:0] DOT_SAT  = 3'd4;
    localparam logic [DOT_W-1:0] DOT_NEED = 3'd3;
    localparam logic [DIG_W-1:0] DIG_MAX  = 3'd3;
    localparam logic [DIG_W-1:0] DIG_SAT  = 3'd4;
    localparam logic [VAL_W-1:0] OCT_MAX  = 10'd255;

    typedef enum logic [1:0] {
        K_DIGIT = 2'd0,
        K_DOT   = 2'd1,
        K_OTHER = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_token;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

endpackage

### sv/ipdq_front.sv
// Front end: accepts character beats and classifies them into tokens.
module ipdq_front (
    input  logic                        i_valid,
    input  logic [ipdq_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_last_char,
    input  ipdq_pkg::t_queue_stat       i_qstat,
    output logic                        o_stall,
    output logic                        o_push,
    output ipdq_pkg::t_token            o_token
);
    import ipdq_pkg::*;

    logic [CHAR_W-1:0] w_off;

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;
    assign w_off   = i_char_code - ASCII_ZERO;

    always_comb begin
        o_token.last  = i_last_char;
        o_token.digit = w_off[3:0];
        if (i_char_code >= ASCII_ZERO && i_char_code <= ASCII_NINE) begin
            o_token.kind = K_DIGIT;
        end else if (i_char_code == ASCII_DOT) begin
            o_token.kind = K_DOT;
        end else begin
            o_token.kind = K_OTHER;
        end
    end

endmodule

### sv/ipdq_queue.sv
// Short token queue between front and back ends.
module ipdq_queue #(
    parameter int DEPTH = ipdq_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ipdq_pkg::t_token      i_token,
    input  logic                  i_pop,
    output ipdq_pkg::t_token      o_head,
    output ipdq_pkg::t_queue_stat o_stat
);
    import ipdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

### sv/ipdq_back.sv
// Back end: running octet/dot/length checks and the verdict output register.
module ipdq_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipdq_pkg::t_token      i_head,
    input  ipdq_pkg::t_queue_stat i_qstat,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic                  o_address_valid
);
    import ipdq_pkg::*;

    logic [CNT_W-1:0] r_char_count, n_char_count;
    logic [DOT_W-1:0] r_dot_count,  n_dot_count;
    logic [DIG_W-1:0] r_dig_count,  n_dig_count;
    logic [VAL_W-1:0] r_oct_value,  n_oct_value;
    logic             r_lead_zero,  n_lead_zero;
    logic             r_error,      n_error;
    logic             r_out_valid,  n_out_valid;
    logic             r_out_data,   n_out_data;

    logic             w_slot_free;
    logic [VAL_W-1:0] w_acc;

    assign w_slot_free     = !r_out_valid || !i_stall;
    assign o_pop           = !i_qstat.empty && (!i_head.last || w_slot_free);
    assign o_valid         = r_out_valid;
    assign o_address_valid = r_out_data;
    assign w_acc = (r_oct_value << 3) + (r_oct_value << 1) + VAL_W'(i_head.digit);

    always_comb begin
        n_char_count = r_char_count;
        n_dot_count  = r_dot_count;
        n_dig_count  = r_dig_count;
        n_oct_value  = r_oct_value;
        n_lead_zero  = r_lead_zero;
        n_error      = r_error;
        n_out_valid  = r_out_valid && i_stall;
        n_out_data   = r_out_data;

        if (o_pop) begin
            if (r_char_count < CNT_SAT) begin
                n_char_count = r_char_count + CNT_W'(1);
            end
            unique case (i_head.kind)
                K_DIGIT: begin
                    if (r_dig_count == '0) begin
                        if (i_head.digit == 4'd0) begin
                            n_lead_zero = 1'b1;
                        end
                    end else if (r_lead_zero) begin
                        n_error = 1'b1;
                    end
                    if (r_dig_count < DIG_MAX) begin
                        n_oct_value = w_acc;
                        if (w_acc > OCT_MAX) begin
                            n_error = 1'b1;
                        end
                    end else begin
                        n_error = 1'b1;
                    end
                    if (r_dig_count < DIG_SAT) begin
                        n_dig_count = r_dig_count + DIG_W'(1);
                    end
                end
                K_DOT: begin
                    if (r_dig_count == '0) begin
                        n_error = 1'b1;
                    end
                    if (r_dot_count == '0 && r_dig_count == DIG_W'(1) && r_lead_zero) begin
                        n_error = 1'b1;
                    end
                    if (r_dot_count < DOT_SAT) begin
                        n_dot_count = r_dot_count + DOT_W'(1);
                    end
                    if (n_dot_count > DOT_NEED) begin
                        n_error = 1'b1;
                    end
                    n_dig_count = '0;
                    n_oct_value = '0;
                    n_lead_zero = 1'b0;
                end
                default: begin
                    n_error = 1'b1;
                end
            endcase

            if (i_head.last) begin
                // closing octet, dot total and length
                if (n_dig_count == '0) begin
                    n_error = 1'b1;
                end
                if (n_dot_count == '0 && n_dig_count == DIG_W'(1) && n_lead_zero) begin
                    n_error = 1'b1;
                end
                if (n_dot_count != DOT_NEED) begin
                    n_error = 1'b1;
                end
                if (n_char_count < LEN_MIN || n_char_count > LEN_MAX) begin
                    n_error = 1'b1;
                end
                n_out_valid  = 1'b1;
                n_out_data   = !n_error;
                n_char_count = '0;
                n_dot_count  = '0;
                n_dig_count  = '0;
                n_oct_value  = '0;
                n_lead_zero  = 1'b0;
                n_error      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_dot_count  <= '0;
            r_dig_count  <= '0;
            r_oct_value  <= '0;
            r_lead_zero  <= 1'b0;
            r_error      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_char_count <= n_char_count;
            r_dot_count  <= n_dot_count;
            r_dig_count  <= n_dig_count;
            r_oct_value  <= n_oct_value;
            r_lead_zero  <= n_lead_zero;
            r_error      <= n_error;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

### sv/ipv4_dotted_quad_validator.sv
// Top level of the dotted-decimal IPv4 address validator.
//
// Input channel: one ASCII character per beat (i_char_code) with i_last_char
// marking the final character of a string. A beat is taken when i_valid is
// high and o_stall is low.
// Output channel: one verdict beat (o_address_valid) per string, on the beat
// after the last character has passed through, taken when o_valid is high
// and i_stall is low.
// Throughput: one character per cycle unless the input or output stalls.
// The last character passes the queue, then the verdict output register.
// A classifier front end feeds tokens into a QUEUE_DEPTH entry queue; the
// back end holds the running checks and drains one token per cycle, but a
// last token waits while the output stalls. o_stall rises only when that
// queue is full. While the receiver stalls, the verdict holds in the output
// register and the back end keeps consuming characters up to the next last
// character; the queue then fills and the input is stalled.
// Reset empties the queue, clears all running state and drops o_valid.
module ipv4_dotted_quad_validator #(
    parameter int QUEUE_DEPTH = ipdq_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ipdq_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_last_char,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_address_valid
);
    import ipdq_pkg::*;

    t_queue_stat w_qstat;
    t_token      w_token;
    t_token      w_head;
    logic        w_push;
    logic        w_pop;

    ipdq_front u_front (
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_qstat     (w_qstat),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_token     (w_token)
    );

    ipdq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_token),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    ipdq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_qstat         (w_qstat),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_address_valid (o_address_valid)
    );

endmodule

### sv/ipdq_checker.sv
// Port-level checks for the validator, bound to the top level.
module ipdq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_address_valid
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall not cleared by reset");

    a_stall_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("input stall rose without an incoming beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("verdict dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_address_valid))
        else $error("verdict changed while stalled");

endmodule

bind ipv4_dotted_quad_validator ipdq_checker u_ipdq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_address_valid (o_address_valid)
);
